@@ sv/segment_intersection_top_macros.svh @@
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every clock while out of reset
`define SEG_ISECT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("seg_isect: implication check failed");
// next-cycle implication
`define SEG_ISECT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("seg_isect: next-cycle check failed");
`else
`define SEG_ISECT_ASSERT_IMP(label, ante, cons)
`define SEG_ISECT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/seg_isect_pkg.sv @@
package seg_isect_pkg;

    // coordinate and fixed-point format
    localparam int CoordW   = 16;
    localparam int FracBits = 8;
    localparam int OutW     = 24;

    // line equation widths
    localparam int AbW   = CoordW + 1;   // a = y1 - y2, b = x1 - x2
    localparam int ProdW = AbW + CoordW; // a*x1, b*y1
    localparam int CW    = ProdW + 1;    // c = a*x1 - b*y1
    localparam int DetPW = 2 * AbW;      // b1*a2, a1*b2
    localparam int DetW  = DetPW + 1;    // determinant
    localparam int PnW   = AbW + CW;     // b1*c2 and friends
    localparam int NumW  = PnW + 1;      // unscaled numerator

    // divider: magnitude quotient bits, one per stage
    localparam int QuotW = 24;
    localparam int ShW   = QuotW - FracBits;
    localparam int RemW  = DetW;

    typedef struct packed {
        logic signed [CoordW-1:0] s1_x1;
        logic signed [CoordW-1:0] s1_y1;
        logic signed [CoordW-1:0] s1_x2;
        logic signed [CoordW-1:0] s1_y2;
        logic signed [CoordW-1:0] s2_x1;
        logic signed [CoordW-1:0] s2_y1;
        logic signed [CoordW-1:0] s2_x2;
        logic signed [CoordW-1:0] s2_y2;
    } t_in_item;

    typedef struct packed {
        logic                   hit;
        logic signed [OutW-1:0] cross_x;
        logic signed [OutW-1:0] cross_y;
    } t_out_item;

    // closed box, integer coordinates
    typedef struct packed {
        logic signed [CoordW-1:0] xlo;
        logic signed [CoordW-1:0] xhi;
        logic signed [CoordW-1:0] ylo;
        logic signed [CoordW-1:0] yhi;
    } t_box;

    // data riding alongside the divider
    typedef struct packed {
        t_box box;
        logic sign_x;
        logic sign_y;
        logic ok;      // det nonzero and both quotients fit
    } t_side;

    typedef struct packed {
        logic [RemW-1:0]  rem_x;
        logic [RemW-1:0]  rem_y;
        logic [QuotW-1:0] lo_x;
        logic [QuotW-1:0] lo_y;
        logic [RemW-1:0]  div;
        t_side            side;
    } t_div_in;

    typedef struct packed {
        logic [QuotW-1:0] q_x;
        logic [QuotW-1:0] q_y;
        t_side            side;
    } t_div_res;

endpackage

@@ sv/seg_isect_eqn.sv @@
module seg_isect_eqn (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  seg_isect_pkg::t_in_item i_data,
    output logic                    o_valid,
    output seg_isect_pkg::t_div_in  o_data
);

    typedef struct packed {
        logic signed [seg_isect_pkg::AbW-1:0]    a1;
        logic signed [seg_isect_pkg::AbW-1:0]    b1;
        logic signed [seg_isect_pkg::AbW-1:0]    a2;
        logic signed [seg_isect_pkg::AbW-1:0]    b2;
        logic signed [seg_isect_pkg::CoordW-1:0] px1;
        logic signed [seg_isect_pkg::CoordW-1:0] py1;
        logic signed [seg_isect_pkg::CoordW-1:0] qx1;
        logic signed [seg_isect_pkg::CoordW-1:0] qy1;
        seg_isect_pkg::t_box                     box1;
        seg_isect_pkg::t_box                     box2;
    } t_st1;

    typedef struct packed {
        logic signed [seg_isect_pkg::ProdW-1:0] ax1;
        logic signed [seg_isect_pkg::ProdW-1:0] by1;
        logic signed [seg_isect_pkg::ProdW-1:0] ax2;
        logic signed [seg_isect_pkg::ProdW-1:0] by2;
        logic signed [seg_isect_pkg::DetPW-1:0] ba;
        logic signed [seg_isect_pkg::DetPW-1:0] ab;
        logic signed [seg_isect_pkg::AbW-1:0]   a1;
        logic signed [seg_isect_pkg::AbW-1:0]   b1;
        logic signed [seg_isect_pkg::AbW-1:0]   a2;
        logic signed [seg_isect_pkg::AbW-1:0]   b2;
        seg_isect_pkg::t_box                    box;
    } t_st2;

    typedef struct packed {
        logic signed [seg_isect_pkg::CW-1:0]   c1;
        logic signed [seg_isect_pkg::CW-1:0]   c2;
        logic signed [seg_isect_pkg::DetW-1:0] det;
        logic signed [seg_isect_pkg::AbW-1:0]  a1;
        logic signed [seg_isect_pkg::AbW-1:0]  b1;
        logic signed [seg_isect_pkg::AbW-1:0]  a2;
        logic signed [seg_isect_pkg::AbW-1:0]  b2;
        seg_isect_pkg::t_box                   box;
    } t_st3;

    typedef struct packed {
        logic signed [seg_isect_pkg::PnW-1:0]  bc2;
        logic signed [seg_isect_pkg::PnW-1:0]  bc1;
        logic signed [seg_isect_pkg::PnW-1:0]  ac2;
        logic signed [seg_isect_pkg::PnW-1:0]  ac1;
        logic signed [seg_isect_pkg::DetW-1:0] det;
        seg_isect_pkg::t_box                   box;
    } t_st4;

    typedef struct packed {
        logic signed [seg_isect_pkg::NumW-1:0] nx;
        logic signed [seg_isect_pkg::NumW-1:0] ny;
        logic signed [seg_isect_pkg::DetW-1:0] det;
        seg_isect_pkg::t_box                   box;
    } t_st5;

    typedef struct packed {
        logic [seg_isect_pkg::NumW-1:0] mag_nx;
        logic [seg_isect_pkg::NumW-1:0] mag_ny;
        logic [seg_isect_pkg::DetW-1:0] mag_d;
        logic                           sign_x;
        logic                           sign_y;
        logic                           det_nz;
        seg_isect_pkg::t_box            box;
    } t_st6;

    t_st1 n_s1, r_s1;
    t_st2 n_s2, r_s2;
    t_st3 n_s3, r_s3;
    t_st4 n_s4, r_s4;
    t_st5 n_s5, r_s5;
    t_st6 n_s6, r_s6;
    seg_isect_pkg::t_div_in n_s7, r_s7;
    logic [6:0] r_vld;

    logic [seg_isect_pkg::NumW-1:0] d_shift;
    logic                           ovf_x;
    logic                           ovf_y;

    // edge differences and per-segment boxes
    always_comb begin
        n_s1.a1   = i_data.s1_y1 - i_data.s1_y2;
        n_s1.b1   = i_data.s1_x1 - i_data.s1_x2;
        n_s1.a2   = i_data.s2_y1 - i_data.s2_y2;
        n_s1.b2   = i_data.s2_x1 - i_data.s2_x2;
        n_s1.px1  = i_data.s1_x1;
        n_s1.py1  = i_data.s1_y1;
        n_s1.qx1  = i_data.s2_x1;
        n_s1.qy1  = i_data.s2_y1;
        n_s1.box1.xlo = (i_data.s1_x1 < i_data.s1_x2) ? i_data.s1_x1 : i_data.s1_x2;
        n_s1.box1.xhi = (i_data.s1_x1 < i_data.s1_x2) ? i_data.s1_x2 : i_data.s1_x1;
        n_s1.box1.ylo = (i_data.s1_y1 < i_data.s1_y2) ? i_data.s1_y1 : i_data.s1_y2;
        n_s1.box1.yhi = (i_data.s1_y1 < i_data.s1_y2) ? i_data.s1_y2 : i_data.s1_y1;
        n_s1.box2.xlo = (i_data.s2_x1 < i_data.s2_x2) ? i_data.s2_x1 : i_data.s2_x2;
        n_s1.box2.xhi = (i_data.s2_x1 < i_data.s2_x2) ? i_data.s2_x2 : i_data.s2_x1;
        n_s1.box2.ylo = (i_data.s2_y1 < i_data.s2_y2) ? i_data.s2_y1 : i_data.s2_y2;
        n_s1.box2.yhi = (i_data.s2_y1 < i_data.s2_y2) ? i_data.s2_y2 : i_data.s2_y1;
    end

    // products for c and det, overlap of the two boxes
    always_comb begin
        n_s2.ax1 = r_s1.a1 * r_s1.px1;
        n_s2.by1 = r_s1.b1 * r_s1.py1;
        n_s2.ax2 = r_s1.a2 * r_s1.qx1;
        n_s2.by2 = r_s1.b2 * r_s1.qy1;
        n_s2.ba  = r_s1.b1 * r_s1.a2;
        n_s2.ab  = r_s1.a1 * r_s1.b2;
        n_s2.a1  = r_s1.a1;
        n_s2.b1  = r_s1.b1;
        n_s2.a2  = r_s1.a2;
        n_s2.b2  = r_s1.b2;
        n_s2.box.xlo = (r_s1.box1.xlo > r_s1.box2.xlo) ? r_s1.box1.xlo : r_s1.box2.xlo;
        n_s2.box.xhi = (r_s1.box1.xhi < r_s1.box2.xhi) ? r_s1.box1.xhi : r_s1.box2.xhi;
        n_s2.box.ylo = (r_s1.box1.ylo > r_s1.box2.ylo) ? r_s1.box1.ylo : r_s1.box2.ylo;
        n_s2.box.yhi = (r_s1.box1.yhi < r_s1.box2.yhi) ? r_s1.box1.yhi : r_s1.box2.yhi;
    end

    // line constants and determinant
    always_comb begin
        n_s3.c1  = r_s2.ax1 - r_s2.by1;
        n_s3.c2  = r_s2.ax2 - r_s2.by2;
        n_s3.det = r_s2.ba - r_s2.ab;
        n_s3.a1  = r_s2.a1;
        n_s3.b1  = r_s2.b1;
        n_s3.a2  = r_s2.a2;
        n_s3.b2  = r_s2.b2;
        n_s3.box = r_s2.box;
    end

    // numerator products
    always_comb begin
        n_s4.bc2 = r_s3.b1 * r_s3.c2;
        n_s4.bc1 = r_s3.b2 * r_s3.c1;
        n_s4.ac2 = r_s3.a1 * r_s3.c2;
        n_s4.ac1 = r_s3.a2 * r_s3.c1;
        n_s4.det = r_s3.det;
        n_s4.box = r_s3.box;
    end

    // numerators
    always_comb begin
        n_s5.nx  = r_s4.bc2 - r_s4.bc1;
        n_s5.ny  = r_s4.ac2 - r_s4.ac1;
        n_s5.det = r_s4.det;
        n_s5.box = r_s4.box;
    end

    // magnitudes and quotient signs
    always_comb begin
        n_s6.mag_nx = r_s5.nx[seg_isect_pkg::NumW-1] ? $unsigned(-r_s5.nx)
                                                     : $unsigned(r_s5.nx);
        n_s6.mag_ny = r_s5.ny[seg_isect_pkg::NumW-1] ? $unsigned(-r_s5.ny)
                                                     : $unsigned(r_s5.ny);
        n_s6.mag_d  = r_s5.det[seg_isect_pkg::DetW-1] ? $unsigned(-r_s5.det)
                                                      : $unsigned(r_s5.det);
        n_s6.sign_x = r_s5.nx[seg_isect_pkg::NumW-1] ^ r_s5.det[seg_isect_pkg::DetW-1];
        n_s6.sign_y = r_s5.ny[seg_isect_pkg::NumW-1] ^ r_s5.det[seg_isect_pkg::DetW-1];
        n_s6.det_nz = (r_s5.det != '0);
        n_s6.box    = r_s5.box;
    end

    // range check: scaled quotient must fit the divider's quotient bits
    assign d_shift = {{(seg_isect_pkg::NumW - seg_isect_pkg::DetW - seg_isect_pkg::ShW){1'b0}},
                      r_s6.mag_d, {seg_isect_pkg::ShW{1'b0}}};
    assign ovf_x   = (r_s6.mag_nx >= d_shift);
    assign ovf_y   = (r_s6.mag_ny >= d_shift);

    // divider set-up: upper bits as first remainder, the rest shifted in later
    always_comb begin
        n_s7.rem_x = r_s6.mag_nx[seg_isect_pkg::ShW +: seg_isect_pkg::RemW];
        n_s7.rem_y = r_s6.mag_ny[seg_isect_pkg::ShW +: seg_isect_pkg::RemW];
        n_s7.lo_x  = {r_s6.mag_nx[seg_isect_pkg::ShW-1:0], {seg_isect_pkg::FracBits{1'b0}}};
        n_s7.lo_y  = {r_s6.mag_ny[seg_isect_pkg::ShW-1:0], {seg_isect_pkg::FracBits{1'b0}}};
        n_s7.div   = r_s6.mag_d;
        n_s7.side.box    = r_s6.box;
        n_s7.side.sign_x = r_s6.sign_x;
        n_s7.side.sign_y = r_s6.sign_y;
        n_s7.side.ok     = r_s6.det_nz && !ovf_x && !ovf_y;
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
        end
    end

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    assign o_valid = r_vld[6];
    assign o_data  = r_s7;

endmodule

@@ sv/seg_isect_div.sv @@
module seg_isect_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  seg_isect_pkg::t_div_in  i_data,
    output logic                    o_valid,
    output seg_isect_pkg::t_div_res o_data
);

    typedef struct packed {
        logic [seg_isect_pkg::RemW-1:0]  rem_x;
        logic [seg_isect_pkg::RemW-1:0]  rem_y;
        logic [seg_isect_pkg::QuotW-1:0] lo_x;
        logic [seg_isect_pkg::QuotW-1:0] lo_y;
        logic [seg_isect_pkg::QuotW-1:0] q_x;
        logic [seg_isect_pkg::QuotW-1:0] q_y;
        logic [seg_isect_pkg::RemW-1:0]  div;
        seg_isect_pkg::t_side            side;
    } t_div_st;

    // one restoring step for both numerators against the shared divisor
    function automatic t_div_st div_step(input t_div_st s);
        t_div_st                        o;
        logic [seg_isect_pkg::RemW+1:0] dx;
        logic [seg_isect_pkg::RemW+1:0] dy;
        o  = s;
        dx = {1'b0, s.rem_x, s.lo_x[seg_isect_pkg::QuotW-1]} - {2'b00, s.div};
        dy = {1'b0, s.rem_y, s.lo_y[seg_isect_pkg::QuotW-1]} - {2'b00, s.div};
        o.q_x   = {s.q_x[seg_isect_pkg::QuotW-2:0], !dx[seg_isect_pkg::RemW+1]};
        o.q_y   = {s.q_y[seg_isect_pkg::QuotW-2:0], !dy[seg_isect_pkg::RemW+1]};
        o.rem_x = dx[seg_isect_pkg::RemW+1]
                ? {s.rem_x[seg_isect_pkg::RemW-2:0], s.lo_x[seg_isect_pkg::QuotW-1]}
                : dx[seg_isect_pkg::RemW-1:0];
        o.rem_y = dy[seg_isect_pkg::RemW+1]
                ? {s.rem_y[seg_isect_pkg::RemW-2:0], s.lo_y[seg_isect_pkg::QuotW-1]}
                : dy[seg_isect_pkg::RemW-1:0];
        o.lo_x  = {s.lo_x[seg_isect_pkg::QuotW-2:0], 1'b0};
        o.lo_y  = {s.lo_y[seg_isect_pkg::QuotW-2:0], 1'b0};
        return o;
    endfunction

    t_div_st                         in_st;
    t_div_st                         n_stg [seg_isect_pkg::QuotW];
    t_div_st                         r_stg [seg_isect_pkg::QuotW];
    logic [seg_isect_pkg::QuotW-1:0] r_vld;

    // entry state: empty quotient
    always_comb begin
        in_st.rem_x = i_data.rem_x;
        in_st.rem_y = i_data.rem_y;
        in_st.lo_x  = i_data.lo_x;
        in_st.lo_y  = i_data.lo_y;
        in_st.q_x   = '0;
        in_st.q_y   = '0;
        in_st.div   = i_data.div;
        in_st.side  = i_data.side;
    end

    // one quotient bit per stage, msb first
    always_comb begin
        n_stg[0] = div_step(in_st);
        for (int k = 1; k < seg_isect_pkg::QuotW; k++) begin
            n_stg[k] = div_step(r_stg[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg <= n_stg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[seg_isect_pkg::QuotW-2:0], i_valid};
        end
    end

    assign o_valid     = r_vld[seg_isect_pkg::QuotW-1];
    assign o_data.q_x  = r_stg[seg_isect_pkg::QuotW-1].q_x;
    assign o_data.q_y  = r_stg[seg_isect_pkg::QuotW-1].q_y;
    assign o_data.side = r_stg[seg_isect_pkg::QuotW-1].side;

endmodule

@@ sv/seg_isect_out.sv @@
module seg_isect_out (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  seg_isect_pkg::t_div_res  i_data,
    input  logic                     i_stall,
    output logic                     o_en,
    output logic                     o_valid,
    output seg_isect_pkg::t_out_item o_data
);

    typedef struct packed {
        logic signed [seg_isect_pkg::QuotW:0] fx;
        logic signed [seg_isect_pkg::QuotW:0] fy;
        seg_isect_pkg::t_side                 side;
    } t_o1;

    t_o1                      n_o1, r_o1;
    logic                     r_o1_vld;
    seg_isect_pkg::t_out_item res;
    seg_isect_pkg::t_out_item n_out, r_out;
    seg_isect_pkg::t_out_item n_skid, r_skid;
    logic                     n_out_vld, r_out_vld;
    logic                     n_skid_vld, r_skid_vld;
    logic                     out_free;
    logic                     hit;

    logic signed [seg_isect_pkg::QuotW:0] blo_x;
    logic signed [seg_isect_pkg::QuotW:0] bhi_x;
    logic signed [seg_isect_pkg::QuotW:0] blo_y;
    logic signed [seg_isect_pkg::QuotW:0] bhi_y;

    // pipeline moves while the skid entry is empty
    assign o_en = !r_skid_vld;

    // apply the quotient sign
    always_comb begin
        n_o1.fx   = i_data.side.sign_x ? -$signed({1'b0, i_data.q_x})
                                       :  $signed({1'b0, i_data.q_x});
        n_o1.fy   = i_data.side.sign_y ? -$signed({1'b0, i_data.q_y})
                                       :  $signed({1'b0, i_data.q_y});
        n_o1.side = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_o1 <= n_o1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_vld <= 1'b0;
        end else if (o_en) begin
            r_o1_vld <= i_valid;
        end
    end

    // box bounds in the fixed-point format
    assign blo_x = {r_o1.side.box.xlo[seg_isect_pkg::CoordW-1], r_o1.side.box.xlo,
                    {seg_isect_pkg::FracBits{1'b0}}};
    assign bhi_x = {r_o1.side.box.xhi[seg_isect_pkg::CoordW-1], r_o1.side.box.xhi,
                    {seg_isect_pkg::FracBits{1'b0}}};
    assign blo_y = {r_o1.side.box.ylo[seg_isect_pkg::CoordW-1], r_o1.side.box.ylo,
                    {seg_isect_pkg::FracBits{1'b0}}};
    assign bhi_y = {r_o1.side.box.yhi[seg_isect_pkg::CoordW-1], r_o1.side.box.yhi,
                    {seg_isect_pkg::FracBits{1'b0}}};

    // hit test, point forced to zero on a miss
    assign hit = r_o1.side.ok
              && (r_o1.fx >= blo_x) && (r_o1.fx <= bhi_x)
              && (r_o1.fy >= blo_y) && (r_o1.fy <= bhi_y);

    always_comb begin
        res.hit     = hit;
        res.cross_x = hit ? r_o1.fx[seg_isect_pkg::OutW-1:0] : '0;
        res.cross_y = hit ? r_o1.fy[seg_isect_pkg::OutW-1:0] : '0;
    end

    // output register with one skid entry behind it
    assign out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_skid     = r_skid;
        n_skid_vld = r_skid_vld;
        if (r_skid_vld) begin
            if (out_free) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end
        end else begin
            if (out_free) begin
                n_out     = res;
                n_out_vld = r_o1_vld;
            end else if (r_o1_vld) begin
                n_skid     = res;
                n_skid_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

@@ sv/segment_intersection_top.sv @@
// Segment intersection: one request carries two segments as 16-bit integer
// endpoints; one result comes back for every request, in order, giving a hit
// flag and the crossing point as signed fixed point with 8 fraction bits
// (zero when there is no hit).
// Input channel: i_valid / i_data, back-pressure on o_stall.
// Output channel: o_valid / o_data, back-pressure from i_stall.
// A request is taken on a clock edge where valid is high and stall is low.
// Throughput: one request per cycle while o_stall is low.
// Pipeline: 33 register stages. The equation stages form the line equations,
// products and magnitudes, a 24-stage restoring divider yields one quotient
// bit per stage for x and y together, a register stage applies the sign, and
// the box test feeds the output register.
// Stall: the output register has one skid entry behind it. o_stall rises only
// when that entry fills; the whole pipeline then holds, nothing lost or
// repeated, and o_stall is registered so it never follows i_stall in the
// same cycle.
// Reset (synchronous, active low) empties every stage; results in flight are
// dropped and o_valid and o_stall go low.
`include "segment_intersection_top_macros.svh"

module segment_intersection_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  seg_isect_pkg::t_in_item  i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output seg_isect_pkg::t_out_item o_data
);

    logic                    pipe_en;
    logic                    eqn_vld;
    seg_isect_pkg::t_div_in  eqn_data;
    logic                    div_vld;
    seg_isect_pkg::t_div_res div_data;

    assign o_stall = !pipe_en;

    // line equations and divider set-up
    seg_isect_eqn u_eqn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (eqn_vld),
        .o_data  (eqn_data)
    );

    // pipelined divider for both coordinates
    seg_isect_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (eqn_vld),
        .i_data  (eqn_data),
        .o_valid (div_vld),
        .o_data  (div_data)
    );

    // sign, box test and output buffering
    seg_isect_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_vld),
        .i_data  (div_data),
        .i_stall (i_stall),
        .o_en    (pipe_en),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    // skid entry only ever sits behind a full output register
    `SEG_ISECT_ASSERT_IMP(a_skid_behind_out, o_stall, o_valid)
    // skid fills only when a held result was refused
    `SEG_ISECT_ASSERT_IMP(a_skid_fill, $rose(o_stall), $past(o_valid) && $past(i_stall))
    // a taken result lets the skid entry move forward at once
    `SEG_ISECT_ASSERT_NEXT(a_skid_drain, o_stall && !i_stall, !o_stall)
    // a miss carries a zero point
    `SEG_ISECT_ASSERT_IMP(a_miss_zero, o_valid && !o_data.hit, o_data.cross_x == '0 && o_data.cross_y == '0)

endmodule
